[src/ftcfd_pkg.sv]
// ----------------------------------------------------------------------------
// ftcfd_pkg
// Shared constants, configuration type and helpers of the fast trapezoid
// filter with constant fraction discriminator.
// ----------------------------------------------------------------------------
package ftcfd_pkg;

  localparam int SAMPLE_BITS_DEF  = 14;
  localparam int WINDOW_DEPTH_DEF = 4096;
  localparam int CFD_DEPTH_DEF    = 64;

  localparam int POS_BITS = 13;
  localparam logic [POS_BITS-1:0] POS_MAX = 13'd8191;

  // scaled window length reaches 127 << 3, sums need 10 extra bits
  localparam int LEN_EXTRA  = 10;
  localparam int SPAN_BITS  = 12;
  localparam int FIFO_DEPTH = 4;

  localparam int CFG_IDX_BITS  = 3;
  localparam int CFG_DATA_BITS = 7;

  localparam logic [CFG_IDX_BITS-1:0] CFG_FAST_LENGTH  = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_FAST_GAP     = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] CFG_FILTER_RANGE = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] CFG_CFD_DELAY    = 3'd3;
  localparam logic [CFG_IDX_BITS-1:0] CFG_CFD_SCALE    = 3'd4;

  typedef struct packed {
    logic [6:0] fast_length;
    logic [6:0] fast_gap;
    logic [1:0] filter_range;
    logic [5:0] cfd_delay;
    logic [2:0] cfd_scale;
  } cfg_t;

  function automatic logic [LEN_EXTRA-1:0] eff_len(cfg_t c);
    logic [LEN_EXTRA-1:0] l;
    l = (c.fast_length == 7'd0) ? 10'd1 : {3'b000, c.fast_length};
    return l << c.filter_range;
  endfunction

  function automatic logic [LEN_EXTRA-1:0] eff_gap(cfg_t c);
    return {3'b000, c.fast_gap} << c.filter_range;
  endfunction

  // 2L + G
  function automatic logic [SPAN_BITS-1:0] eff_span(cfg_t c);
    return {1'b0, eff_len(c), 1'b0} + {2'b00, eff_gap(c)};
  endfunction

endpackage

[src/ftcfd_ram.sv]
// ----------------------------------------------------------------------------
// ftcfd_ram
// Generic one write, one read RAM with registered read data.
// ----------------------------------------------------------------------------
module ftcfd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[src/ftcfd_fifo.sv]
// ----------------------------------------------------------------------------
// ftcfd_fifo
// Short queue of classified samples between the front and the back end.
// ----------------------------------------------------------------------------
module ftcfd_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       push_i,
  input  logic [WIDTH-1:0]           data_i,
  input  logic                       pop_i,
  output logic [WIDTH-1:0]           data_o,
  output logic                       valid_o,
  output logic [$clog2(DEPTH+1)-1:0] level_o
);

  localparam int PW = $clog2(DEPTH);
  localparam int LW = $clog2(DEPTH+1);

  logic [WIDTH-1:0] slot_q [DEPTH];
  logic [PW-1:0]    wp_q, rp_q;
  logic [LW-1:0]    level_q;
  logic             do_pop;

  assign do_pop = pop_i && (level_q != '0);

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wp_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q    <= '0;
      rp_q    <= '0;
      level_q <= '0;
    end else begin
      if (push_i) begin
        wp_q <= (wp_q == PW'(DEPTH-1)) ? '0 : wp_q + 1'b1;
      end
      if (do_pop) begin
        rp_q <= (rp_q == PW'(DEPTH-1)) ? '0 : rp_q + 1'b1;
      end
      if (push_i && !do_pop) begin
        level_q <= level_q + 1'b1;
      end else if (!push_i && do_pop) begin
        level_q <= level_q - 1'b1;
      end
    end
  end

  assign data_o  = slot_q[rp_q];
  assign valid_o = (level_q != '0);
  assign level_o = level_q;

endmodule

[src/ftcfd_front.sv]
// ----------------------------------------------------------------------------
// ftcfd_front
// Sample intake: prefix sum history, window sum difference, warm-up test.
// ----------------------------------------------------------------------------
module ftcfd_front import ftcfd_pkg::*; #(
  parameter int SAMPLE_BITS  = SAMPLE_BITS_DEF,
  parameter int WINDOW_DEPTH = WINDOW_DEPTH_DEF,
  parameter int CFD_DEPTH    = CFD_DEPTH_DEF,
  parameter int QDEPTH       = FIFO_DEPTH,
  parameter int ITEMW        = SAMPLE_BITS + LEN_EXTRA + 1 + POS_BITS + $clog2(CFD_DEPTH) + 2
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  cfg_t                        cfg_i,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [SAMPLE_BITS-1:0]      sample_i,
  input  logic                        last_i,
  input  logic [$clog2(QDEPTH+1)-1:0] q_level_i,
  output logic                        push_o,
  output logic [ITEMW-1:0]            item_o
);

  localparam int SUMW = SAMPLE_BITS + LEN_EXTRA;
  localparam int AW   = $clog2(WINDOW_DEPTH);
  localparam int CW   = $clog2(CFD_DEPTH);
  localparam int IW   = ((AW > SPAN_BITS) ? AW : SPAN_BITS) + 2;
  localparam int LW   = $clog2(QDEPTH+1);

  logic [POS_BITS-1:0] pos_q, x1_q;
  logic [CW-1:0]       xm_q, xm1_q;
  logic [AW-1:0]       wr_q, wr_d;
  logic [SUMW-1:0]     pref_q, pref_d, pref1_q;
  logic                valid1_q, emit1_q, last1_q, zc1_q;
  logic                accept, first;
  logic [SPAN_BITS-1:0] k_a, k_b, k_c;
  logic [AW-1:0]       addr_a, addr_b, addr_c;
  logic [SUMW-1:0]     rd_a, rd_b, rd_c;
  logic [SUMW-1:0]     recent, early;
  logic [SUMW:0]       diff;
  logic [POS_BITS:0]   x_inc;
  logic                emit, zc;

  function automatic logic [AW-1:0] back_addr(logic [AW-1:0] wr, logic [SPAN_BITS-1:0] k);
    logic [IW-1:0] t;
    t = IW'(wr) + IW'(WINDOW_DEPTH) - IW'(k);
    if (t >= IW'(WINDOW_DEPTH)) begin
      t = t - IW'(WINDOW_DEPTH);
    end
    return t[AW-1:0];
  endfunction

  assign in_ready_o = ((LW+1)'(q_level_i) + (LW+1)'(valid1_q)) < (LW+1)'(QDEPTH);
  assign accept     = in_valid_i && in_ready_o;
  assign first      = (pos_q == '0);

  always_comb begin
    if (first || wr_q == AW'(WINDOW_DEPTH-1)) begin
      wr_d = '0;
    end else begin
      wr_d = wr_q + 1'b1;
    end
  end

  assign pref_d = (first ? '0 : pref_q) + SUMW'(sample_i);

  assign k_a   = SPAN_BITS'(eff_len(cfg_i));
  assign k_b   = SPAN_BITS'(eff_len(cfg_i)) + SPAN_BITS'(eff_gap(cfg_i));
  assign k_c   = eff_span(cfg_i);
  assign x_inc = {1'b0, pos_q} + 1'b1;
  assign emit  = x_inc >= (POS_BITS+1)'(k_c);
  assign zc    = x_inc == (POS_BITS+1)'(k_c);

  assign addr_a = back_addr(wr_d, k_a);
  assign addr_b = back_addr(wr_d, k_b);
  assign addr_c = back_addr(wr_d, k_c);

  ftcfd_ram #(.WIDTH(SUMW), .DEPTH(WINDOW_DEPTH)) u_ram_a (
    .clk_i, .we_i(accept), .waddr_i(wr_d), .wdata_i(pref_d),
    .raddr_i(addr_a), .rdata_o(rd_a)
  );
  ftcfd_ram #(.WIDTH(SUMW), .DEPTH(WINDOW_DEPTH)) u_ram_b (
    .clk_i, .we_i(accept), .waddr_i(wr_d), .wdata_i(pref_d),
    .raddr_i(addr_b), .rdata_o(rd_b)
  );
  ftcfd_ram #(.WIDTH(SUMW), .DEPTH(WINDOW_DEPTH)) u_ram_c (
    .clk_i, .we_i(accept), .waddr_i(wr_d), .wdata_i(pref_d),
    .raddr_i(addr_c), .rdata_o(rd_c)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q    <= '0;
      xm_q     <= '0;
      wr_q     <= '0;
      pref_q   <= '0;
      valid1_q <= 1'b0;
    end else begin
      valid1_q <= accept;
      if (accept) begin
        wr_q   <= wr_d;
        pref_q <= pref_d;
        if (last_i) begin
          pos_q <= '0;
          xm_q  <= '0;
        end else if (pos_q < POS_MAX) begin
          pos_q <= pos_q + 1'b1;
          xm_q  <= (xm_q == CW'(CFD_DEPTH-1)) ? '0 : xm_q + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      x1_q    <= pos_q;
      xm1_q   <= xm_q;
      pref1_q <= pref_d;
      emit1_q <= emit;
      last1_q <= last_i;
      zc1_q   <= zc;
    end
  end

  assign recent = pref1_q - rd_a;
  assign early  = rd_b - (zc1_q ? '0 : rd_c);
  assign diff   = {1'b0, recent} - {1'b0, early};

  assign push_o = valid1_q;
  assign item_o = {diff, x1_q, xm1_q, emit1_q, last1_q};

endmodule

[src/ftcfd_back.sv]
// ----------------------------------------------------------------------------
// ftcfd_back
// Result engine: bit-serial divide by the window length, CFD, result register.
// ----------------------------------------------------------------------------
module ftcfd_back import ftcfd_pkg::*; #(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
  parameter int CFD_DEPTH   = CFD_DEPTH_DEF,
  parameter int ITEMW       = SAMPLE_BITS + LEN_EXTRA + 1 + POS_BITS + $clog2(CFD_DEPTH) + 2
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  cfg_t                          cfg_i,
  input  logic                          item_valid_i,
  input  logic [ITEMW-1:0]              item_i,
  output logic                          pop_o,
  output logic                          res_valid_o,
  input  logic                          res_ready_i,
  output logic signed [SAMPLE_BITS+3:0] fast_o,
  output logic signed [SAMPLE_BITS+7:0] cfd_o,
  output logic                          cfd_valid_o,
  output logic                          trace_end_o
);

  localparam int SUMW  = SAMPLE_BITS + LEN_EXTRA;
  localparam int NUMW  = SUMW + 3;
  localparam int FASTW = SAMPLE_BITS + 4;
  localparam int CFDW  = SAMPLE_BITS + 8;
  localparam int CW    = $clog2(CFD_DEPTH);
  localparam int NCW   = $clog2(NUMW);
  localparam logic [8:0] CFD_LAST = 9'(CFD_DEPTH - 1);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_DIV  = 2'd1;
  localparam logic [1:0] ST_CALC = 2'd2;
  localparam logic [1:0] ST_OUT  = 2'd3;

  logic [1:0]          state_q;
  logic [SUMW:0]       it_diff;
  logic [POS_BITS-1:0] it_x, x_q;
  logic [CW-1:0]       it_xm, xm_q;
  logic                it_emit, it_last, last_q, neg_q;
  logic [SUMW-1:0]     mag;
  logic [NUMW-1:0]     num_q;
  logic [6:0]          rem_q, dvs, rem_n;
  logic [7:0]          rem2;
  logic                qbit;
  logic [NCW-1:0]      cnt_q;
  logic                seen_q;
  logic signed [FASTW-1:0] ff_q, fq, firstv, fd, line_rd;
  logic [8:0]          d9;
  logic [CW-1:0]       d;
  logic [CW:0]         raddr_w;
  logic [CW-1:0]       raddr;
  logic                cvalid, use_first;
  logic [3:0]          sc;
  logic signed [CFDW:0] fq_x, fd_x, sc_x, prod, cfd_full;
  logic signed [FASTW-1:0] fast_q;
  logic signed [CFDW-1:0]  cfd_q;
  logic                cval_q, end_q;

  assign {it_diff, it_x, it_xm, it_emit, it_last} = item_i;
  assign mag   = it_diff[SUMW] ? SUMW'(~it_diff + 1'b1) : it_diff[SUMW-1:0];
  assign pop_o = (state_q == ST_IDLE) && item_valid_i;

  assign dvs   = (cfg_i.fast_length == 7'd0) ? 7'd1 : cfg_i.fast_length;
  assign rem2  = {rem_q, num_q[NUMW-1]};
  assign qbit  = rem2 >= {1'b0, dvs};
  assign rem_n = qbit ? 7'(rem2 - {1'b0, dvs}) : rem2[6:0];

  assign d9      = ({3'b000, cfg_i.cfd_delay} > CFD_LAST) ? CFD_LAST : {3'b000, cfg_i.cfd_delay};
  assign d       = d9[CW-1:0];
  assign raddr_w = (xm_q >= d) ? {1'b0, xm_q} - {1'b0, d}
                               : {1'b0, xm_q} + (CW+1)'(CFD_DEPTH) - {1'b0, d};
  assign raddr   = raddr_w[CW-1:0];

  ftcfd_ram #(.WIDTH(FASTW), .DEPTH(CFD_DEPTH)) u_fast_line (
    .clk_i,
    .we_i   (state_q == ST_CALC),
    .waddr_i(xm_q),
    .wdata_i(fq),
    .raddr_i(raddr),
    .rdata_o(line_rd)
  );

  assign fq        = neg_q ? FASTW'(FASTW'(0) - num_q[FASTW-1:0]) : num_q[FASTW-1:0];
  assign firstv    = seen_q ? ff_q : fq;
  assign cvalid    = x_q >= {7'd0, cfg_i.cfd_delay};
  assign use_first = ({1'b0, x_q} + 1'b1) < ((POS_BITS+1)'(d) + (POS_BITS+1)'(eff_span(cfg_i)));
  assign fd        = use_first ? firstv : ((d == '0) ? fq : line_rd);
  assign sc        = 4'd8 - {1'b0, cfg_i.cfd_scale};
  assign fq_x      = (CFDW+1)'(fq);
  assign fd_x      = (CFDW+1)'(fd);
  assign sc_x      = (CFDW+1)'($signed({1'b0, sc}));
  assign prod      = fq_x * sc_x;
  assign cfd_full  = prod - (fd_x <<< 3);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      seen_q  <= 1'b0;
    end else begin
      case (state_q)
        ST_IDLE: begin
          if (item_valid_i) begin
            if (it_emit) begin
              state_q <= ST_DIV;
            end else if (it_last) begin
              seen_q <= 1'b0;
            end
          end
        end
        ST_DIV: begin
          if (cnt_q == '0) begin
            state_q <= ST_CALC;
          end
        end
        ST_CALC: begin
          seen_q  <= last_q ? 1'b0 : 1'b1;
          state_q <= ST_OUT;
        end
        ST_OUT: begin
          if (res_ready_i) begin
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        num_q  <= NUMW'({mag, 3'b000} >> cfg_i.filter_range);
        rem_q  <= '0;
        cnt_q  <= NCW'(NUMW - 1);
        neg_q  <= it_diff[SUMW];
        x_q    <= it_x;
        xm_q   <= it_xm;
        last_q <= it_last;
      end
      ST_DIV: begin
        rem_q <= rem_n;
        num_q <= {num_q[NUMW-2:0], qbit};
        cnt_q <= cnt_q - 1'b1;
      end
      ST_CALC: begin
        if (!seen_q) begin
          ff_q <= fq;
        end
        fast_q <= fq;
        cfd_q  <= cvalid ? cfd_full[CFDW-1:0] : '0;
        cval_q <= cvalid;
        end_q  <= last_q;
      end
      default: ;
    endcase
  end

  assign res_valid_o = (state_q == ST_OUT);
  assign fast_o      = fast_q;
  assign cfd_o       = cfd_q;
  assign cfd_valid_o = cval_q;
  assign trace_end_o = end_q;

endmodule

[src/fast_trapezoid_cfd_filter.sv]
// ----------------------------------------------------------------------------
// fast_trapezoid_cfd_filter
// Fast trapezoidal filter with constant fraction discriminator.
//
// Samples enter on the sample channel (valid/ready); one transfer per sample.
// last_sample_i ends a trace and the next sample starts a new one.
// Results leave on the result channel (valid/ready). Warm-up samples, those
// before position 2L+G-1, give no result.
// The front end takes one sample per cycle into a 4-entry queue while the
// queue has room; it writes the prefix-sum history and reads three window
// taps from its RAMs. The back end handles one item at a time: it loads
// the item, divides by the window length one bit per cycle, computes the
// CFD and holds the result until it is taken. A warm-up sample is popped
// without a result.
// When the receiver stalls the result is held; the queue then fills and
// sample_ready_o drops.
// Reset clears positions, sums and the queue; configuration returns to its
// defaults. Configuration is written with cfg_we_i, cfg_index_i, cfg_data_i.
// ----------------------------------------------------------------------------
module fast_trapezoid_cfd_filter import ftcfd_pkg::*; #(
  parameter int SAMPLE_BITS  = SAMPLE_BITS_DEF,
  parameter int WINDOW_DEPTH = WINDOW_DEPTH_DEF,
  parameter int CFD_DEPTH    = CFD_DEPTH_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [CFG_IDX_BITS-1:0]       cfg_index_i,
  input  logic [CFG_DATA_BITS-1:0]      cfg_data_i,
  input  logic                          sample_valid_i,
  output logic                          sample_ready_o,
  input  logic [SAMPLE_BITS-1:0]        sample_i,
  input  logic                          last_sample_i,
  output logic                          result_valid_o,
  input  logic                          result_ready_i,
  output logic signed [SAMPLE_BITS+3:0] fast_value_o,
  output logic signed [SAMPLE_BITS+7:0] cfd_value_o,
  output logic                          cfd_valid_o,
  output logic                          trace_end_o
);

  localparam int ITEMW = SAMPLE_BITS + LEN_EXTRA + 1 + POS_BITS + $clog2(CFD_DEPTH) + 2;
  localparam int LW    = $clog2(FIFO_DEPTH+1);

  cfg_t             cfg_q;
  logic             push, pop, q_valid;
  logic [ITEMW-1:0] item_in, item_out;
  logic [LW-1:0]    q_level;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.fast_length  <= 7'd1;
      cfg_q.fast_gap     <= 7'd0;
      cfg_q.filter_range <= 2'd0;
      cfg_q.cfd_delay    <= 6'd1;
      cfg_q.cfd_scale    <= 3'd0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_FAST_LENGTH:  cfg_q.fast_length  <= cfg_data_i;
        CFG_FAST_GAP:     cfg_q.fast_gap     <= cfg_data_i;
        CFG_FILTER_RANGE: cfg_q.filter_range <= cfg_data_i[1:0];
        CFG_CFD_DELAY:    cfg_q.cfd_delay    <= cfg_data_i[5:0];
        CFG_CFD_SCALE:    cfg_q.cfd_scale    <= cfg_data_i[2:0];
        default: ;
      endcase
    end
  end

  ftcfd_front #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .WINDOW_DEPTH(WINDOW_DEPTH),
    .CFD_DEPTH   (CFD_DEPTH),
    .QDEPTH      (FIFO_DEPTH),
    .ITEMW       (ITEMW)
  ) u_front (
    .clk_i,
    .rst_ni,
    .cfg_i     (cfg_q),
    .in_valid_i(sample_valid_i),
    .in_ready_o(sample_ready_o),
    .sample_i,
    .last_i    (last_sample_i),
    .q_level_i (q_level),
    .push_o    (push),
    .item_o    (item_in)
  );

  ftcfd_fifo #(.WIDTH(ITEMW), .DEPTH(FIFO_DEPTH)) u_fifo (
    .clk_i,
    .rst_ni,
    .push_i (push),
    .data_i (item_in),
    .pop_i  (pop),
    .data_o (item_out),
    .valid_o(q_valid),
    .level_o(q_level)
  );

  ftcfd_back #(
    .SAMPLE_BITS(SAMPLE_BITS),
    .CFD_DEPTH  (CFD_DEPTH),
    .ITEMW      (ITEMW)
  ) u_back (
    .clk_i,
    .rst_ni,
    .cfg_i       (cfg_q),
    .item_valid_i(q_valid),
    .item_i      (item_out),
    .pop_o       (pop),
    .res_valid_o (result_valid_o),
    .res_ready_i (result_ready_i),
    .fast_o      (fast_value_o),
    .cfd_o       (cfd_value_o),
    .cfd_valid_o,
    .trace_end_o
  );

endmodule

[test/tb_fast_trapezoid_cfd_filter.sv]
// ----------------------------------------------------------------------------
// tb_fast_trapezoid_cfd_filter
// Self-checking bench for the fast trapezoid filter with CFD. Samples are
// sent as traces under a series of filter settings, both extremes included,
// with random gaps and result stalls. An in-bench model predicts every
// result, and the scoreboard compares each result transfer with it.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_fast_trapezoid_cfd_filter;
  import ftcfd_pkg::*;

  localparam int LINE_DEPTH = 4096;
  localparam int FAST_DEPTH = 64;
  localparam int STALL_LIMIT = 5000;

  typedef struct {
    logic [17:0] fast;
    logic [21:0] cfd;
    logic        cfd_ok;
    logic        tend;
  } trap_result_t;

  class trap_scoreboard;
    bit [13:0]    line [LINE_DEPTH];
    int           fline [FAST_DEPTH];
    int           pos, wptr, first_fast;
    bit           seen;
    int           flen = 1, fgap = 0, frange = 0, delay = 1, scale = 0;
    trap_result_t pending [$];
    int           errors, checked, predicted;

    function void restart();
      pos = 0; wptr = 0; first_fast = 0; seen = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_BITS-1:0] idx, int v);
      case (idx)
        CFG_FAST_LENGTH:  flen = v & 127;
        CFG_FAST_GAP:     fgap = v & 127;
        CFG_FILTER_RANGE: frange = v & 3;
        CFG_CFD_DELAY:    delay = v & 63;
        CFG_CFD_SCALE:    scale = v & 7;
        default: ;
      endcase
    endfunction

    function int span();
      return 2 * ((flen == 0 ? 1 : flen) << frange) + (fgap << frange);
    endfunction

    function void note_sample(bit [13:0] s, bit last);
      int len, gap, offset, x, d;
      longint rsum, esum, fq, fd, cfd;
      trap_result_t r;
      len = (flen == 0 ? 1 : flen) << frange;
      gap = fgap << frange;
      offset = 2 * len + gap - 1;
      x = pos;
      wptr = (x == 0) ? 0 : (wptr + 1) % LINE_DEPTH;
      line[wptr] = s;
      if (x >= offset) begin
        rsum = 0;
        esum = 0;
        for (int k = 0; k < len; k++)
          rsum += line[(wptr + LINE_DEPTH - k % LINE_DEPTH) % LINE_DEPTH];
        for (int k = len + gap; k < 2 * len + gap; k++)
          esum += line[(wptr + LINE_DEPTH - k % LINE_DEPTH) % LINE_DEPTH];
        fq = ((rsum - esum) * 8) / longint'(len);
        if (!seen) begin
          first_fast = int'(fq);
          seen = 1;
        end
        d = (delay >= FAST_DEPTH) ? FAST_DEPTH - 1 : delay;
        cfd = 0;
        r.cfd_ok = (x >= delay);
        if (r.cfd_ok) begin
          if (x - d < offset) fd = first_fast;
          else if (d == 0) fd = fq;
          else fd = fline[(x - d) % FAST_DEPTH];
          cfd = fq * (8 - scale) - fd * 8;
        end
        fline[x % FAST_DEPTH] = int'(fq);
        r.fast = fq[17:0];
        r.cfd = cfd[21:0];
        r.tend = last;
        pending.push_back(r);
        predicted++;
      end
      if (pos < 8191) pos++;
      if (last) restart();
    endfunction

    task report(string what);
      $display("mismatch @%0t: %s", $realtime, what);
      errors++;
    endtask

    task check_result(logic [17:0] f, logic [21:0] c, logic cv, logic te);
      trap_result_t e;
      checked++;
      if (pending.size() == 0) begin
        report("result with none expected");
      end else begin
        e = pending.pop_front();
        if (f !== e.fast) report($sformatf("fast_value %h, want %h", f, e.fast));
        if (c !== e.cfd) report($sformatf("cfd_value %h, want %h", c, e.cfd));
        if (cv !== e.cfd_ok) report($sformatf("cfd_valid %b, want %b", cv, e.cfd_ok));
        if (te !== e.tend) report($sformatf("trace_end %b, want %b", te, e.tend));
      end
    endtask
  endclass

  logic                          clk_i = 0;
  logic                          rst_ni = 0;
  logic                          cfg_we_i = 0;
  logic [CFG_IDX_BITS-1:0]       cfg_index_i = '0;
  logic [CFG_DATA_BITS-1:0]      cfg_data_i = '0;
  logic                          sample_valid_i = 0;
  logic                          sample_ready_o;
  logic [13:0]                   sample_i = '0;
  logic                          last_sample_i = 0;
  logic                          result_valid_o;
  logic                          result_ready_i = 0;
  logic signed [17:0]            fast_value_o;
  logic signed [21:0]            cfd_value_o;
  logic                          cfd_valid_o;
  logic                          trace_end_o;

  trap_scoreboard sb = new();
  bit calm = 0;
  int idle_cycles = 0;
  int samples_sent = 0;
  int settings_used = 1;
  int stall_left = 0;

  fast_trapezoid_cfd_filter uut (.*);

  always #10 clk_i = ~clk_i;

  // result side: check transfers, random stall bursts
  always @(posedge clk_i) begin
    if (rst_ni && result_valid_o && result_ready_i)
      sb.check_result(fast_value_o, cfd_value_o, cfd_valid_o, trace_end_o);
    if (stall_left > 0) begin
      stall_left--;
      result_ready_i <= 0;
    end else if (!calm && $urandom_range(0, 9) == 0) begin
      stall_left = $urandom_range(1, 9) - 1;
      result_ready_i <= 0;
    end else begin
      result_ready_i <= 1;
    end
  end

  always @(posedge clk_i) begin
    if ((sample_valid_i && sample_ready_o) || (result_valid_o && result_ready_i))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("timeout: no transfer for %0d cycles", STALL_LIMIT);
      $display("== FAIL ==");
      $finish;
    end
  end

  task send_sample(bit [13:0] s, bit last);
    if (!calm && $urandom_range(0, 7) == 0) begin
      sample_valid_i <= 0;
      repeat ($urandom_range(1, 9)) @(posedge clk_i);
    end
    sample_valid_i <= 1;
    sample_i <= s;
    last_sample_i <= last;
    do @(posedge clk_i); while (!sample_ready_o);
    sb.note_sample(s, last);
    samples_sent++;
  endtask

  task drain();
    sample_valid_i <= 0;
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
  endtask

  task write_reg(logic [CFG_IDX_BITS-1:0] idx, int v);
    cfg_we_i <= 1;
    cfg_index_i <= idx;
    cfg_data_i <= v[CFG_DATA_BITS-1:0];
    @(posedge clk_i);
    sb.write_reg(idx, v);
  endtask

  task set_filter(int len, int gap, int rng, int dly, int scl);
    write_reg(CFG_FAST_LENGTH, len);
    write_reg(CFG_FAST_GAP, gap);
    write_reg(CFG_FILTER_RANGE, rng);
    write_reg(CFG_CFD_DELAY, dly);
    write_reg(CFG_CFD_SCALE, scl);
    cfg_we_i <= 0;
    @(posedge clk_i);
    settings_used++;
  endtask

  // sends whole traces until about want samples have gone out
  task run_traces(int want);
    int goal, tlen, shape, base;
    bit [13:0] s;
    goal = samples_sent + want;
    while (samples_sent < goal) begin
      tlen = ($urandom_range(0, 4) == 0) ? $urandom_range(1, sb.span())
                                         : sb.span() - 1 + $urandom_range(1, 60);
      shape = $urandom_range(0, 2);
      base = $urandom_range(0, 16383);
      for (int i = 0; i < tlen; i++) begin
        case (shape)
          0: s = $urandom_range(0, 16383);
          1: s = (base + $urandom_range(0, 2000)) % 16384;
          default: s = $urandom_range(0, 1) ? 14'h3fff : 14'h0000;
        endcase
        send_sample(s, i == tlen - 1);
      end
    end
    drain();
  endtask

  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);

    // defaults: warm-up restart, full-scale steps
    send_sample(14'h0000, 1);
    send_sample(14'h3fff, 1);
    send_sample(14'h3fff, 0);
    send_sample(14'h0000, 0);
    send_sample(14'h3fff, 0);
    send_sample(14'h3fff, 0);
    send_sample(14'h0000, 0);
    send_sample(14'h2aaa, 0);
    send_sample(14'h1555, 1);
    drain();

    set_filter(0, 0, 0, 0, 7);
    run_traces(40);
    set_filter(127, 127, 0, 63, 7);
    run_traces(400);
    set_filter(3, 2, 1, 5, 3);
    run_traces(60);
    repeat (5) begin
      set_filter($urandom_range(0, 6), $urandom_range(0, 6), $urandom_range(0, 1),
                 $urandom_range(0, 63), $urandom_range(0, 7));
      run_traces(40);
    end
    calm = 1;
    set_filter(1, 1, 3, 2, 4);
    run_traces(60);

    $display("covered %0d samples, %0d results, %0d filter settings",
             samples_sent, sb.checked, settings_used);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("%0d mismatches, %0d results outstanding", sb.errors, sb.pending.size());
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
